// ----- sv/sorted_unique_set_unit_assert.svh -----
// Assertion helpers shared by the sorted set RTL.
// SUS_ASSERT expects clk_i and rst_ni in scope; SUS_ASSERT_ALWAYS needs only clk_i.
`ifndef SORTED_UNIQUE_SET_UNIT_ASSERT_SVH
`define SORTED_UNIQUE_SET_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SUS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SUS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- sv/sus_pkg.sv -----
`default_nettype none
package sus_pkg;

  localparam int unsigned CAPACITY_DEF = 8;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned FILL_W       = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_e;

  // Contents of one cell as seen by its neighbors
  typedef struct packed {
    logic                      occ;
    logic signed [VALUE_W-1:0] entry;
  } cell_t;

endpackage
`default_nettype wire

// ----- sv/sus_in_if.sv -----
`default_nettype none
interface sus_in_if;
  import sus_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

// ----- sv/sus_out_if.sv -----
`default_nettype none
interface sus_out_if;
  import sus_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] entry;
  logic [FILL_W-1:0]         fill_count;
  logic                      last;

  modport source (output valid, output status, output entry, output fill_count,
                  output last, input ready);
  modport sink (input valid, input status, input entry, input fill_count,
                input last, output ready);
endinterface
`default_nettype wire

// ----- sv/sus_cell.sv -----
`default_nettype none
module sus_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire sus_pkg::cell_op_e                 op_i,
  input  wire logic signed [sus_pkg::VALUE_W-1:0] key_i,
  input  wire logic signed [sus_pkg::VALUE_W-1:0] head_i,
  input  wire sus_pkg::cell_t                    left_i,
  input  wire logic                              left_lt_i,
  input  wire sus_pkg::cell_t                    right_i,
  output      sus_pkg::cell_t                    cell_o,
  output      logic                              lt_o,
  output      logic                              eq_o
);
  import sus_pkg::*;

  logic                      occ_q, occ_d;
  logic signed [VALUE_W-1:0] entry_q, entry_d;

  // Compare own word against the key
  assign lt_o   = occ_q && (entry_q < key_i);
  assign eq_o   = occ_q && (entry_q == key_i);
  assign cell_o = '{occ: occ_q, entry: entry_q};

  // Keep, take the key, or take a neighbor's word
  always_comb begin
    occ_d   = occ_q;
    entry_d = entry_q;
    unique case (op_i)
      OP_HOLD: begin
      end
      OP_INSERT: begin
        occ_d = occ_q | left_i.occ;
        if (!lt_o) begin
          entry_d = left_lt_i ? key_i : left_i.entry;
        end
      end
      OP_DELETE: begin
        occ_d = right_i.occ;
        if (!lt_o) begin
          entry_d = right_i.entry;
        end
      end
      OP_ROTATE: begin
        entry_d = (occ_q && !right_i.occ) ? head_i : right_i.entry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

// ----- sv/sorted_unique_set_unit.sv -----
// Sorted set of distinct signed 32-bit words, up to CAPACITY of them.
// Input channel in_i carries a command (insert, delete, list) and a value;
// output channel out_o carries status, entry, fill_count and last.
// Insert and delete: once accepted, the single result sits in the
// output register on the next cycle. The row of cells compares and shifts
// all words in the cycle of acceptance, so one insert or delete per cycle sustains
// while the receiver keeps up.
// List: emits fill_count results, one per cycle while the receiver keeps up,
// by rotating the row left and reading the head cell; the command moves the
// unit to the list state, which loads each word into the output register,
// and no new command is accepted until the last word is loaded. On an
// empty set it gives one empty result. Command code 3 is accepted and gives
// no result.
// When the receiver holds ready low the output register keeps its word and
// the input side waits; nothing is lost or repeated.
// Reset clears the fill count and all occupancy flags; the set is usable
// on the first cycle after reset.
`default_nettype none
`include "sorted_unique_set_unit_assert.svh"
module sorted_unique_set_unit #(
  parameter int unsigned CAPACITY = sus_pkg::CAPACITY_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  sus_in_if.sink   in_i,
  sus_out_if.source out_o
);
  import sus_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  state_e                    state_q, state_d;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             remain_q, remain_d;
  logic                      out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]       out_status_q, out_status_d;
  logic signed [VALUE_W-1:0] out_entry_q, out_entry_d;
  logic [FILL_W-1:0]         out_fill_q, out_fill_d;
  logic                      out_last_q, out_last_d;

  cell_op_e                  op;
  cell_t                     link [CAPACITY+2];
  logic [CAPACITY:0]         lt_chain;
  logic [CAPACITY-1:0]       eq_vec;
  logic [CAPACITY-1:0]       occ_vec;
  logic                      full, found, slot_free, in_fire;

  // Row boundaries: the left end looks occupied and below every key
  assign link[0]          = '{occ: 1'b1, entry: '0};
  assign link[CAPACITY+1] = '{occ: 1'b0, entry: '0};
  assign lt_chain[0]      = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sus_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op),
      .key_i     (in_i.value),
      .head_i    (link[1].entry),
      .left_i    (link[i]),
      .left_lt_i (lt_chain[i]),
      .right_i   (link[i+2]),
      .cell_o    (link[i+1]),
      .lt_o      (lt_chain[i+1]),
      .eq_o      (eq_vec[i])
    );
    assign occ_vec[i] = link[i+1].occ;
  end

  assign full      = (count_q == CW'(CAPACITY));
  assign found     = |eq_vec;
  assign slot_free = !out_valid_q || out_o.ready;
  assign in_fire   = in_i.valid && in_i.ready;

  assign in_i.ready       = (state_q == S_IDLE) && slot_free;
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.entry      = out_entry_q;
  assign out_o.fill_count = out_fill_q;
  assign out_o.last       = out_last_q;

  // Decode the command, pick the row operation, build the next result
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    remain_d     = remain_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_fill_d   = out_fill_q;
    out_last_d   = out_last_q;
    op           = OP_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd_e'(in_i.command))
            CMD_INSERT: begin
              out_valid_d = 1'b1;
              out_entry_d = '0;
              out_last_d  = 1'b1;
              if (full) begin
                out_status_d = ST_FULL;
              end else if (found) begin
                out_status_d = ST_DUP;
              end else begin
                out_status_d = ST_DONE;
                op           = OP_INSERT;
                count_d      = count_q + CW'(1);
              end
              out_fill_d = FILL_W'(count_d);
            end
            CMD_DELETE: begin
              out_valid_d = 1'b1;
              out_entry_d = '0;
              out_last_d  = 1'b1;
              if (count_q == '0) begin
                out_status_d = ST_EMPTY;
              end else if (!found) begin
                out_status_d = ST_NOTFOUND;
              end else begin
                out_status_d = ST_DONE;
                op           = OP_DELETE;
                count_d      = count_q - CW'(1);
              end
              out_fill_d = FILL_W'(count_d);
            end
            CMD_LIST: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_status_d = ST_EMPTY;
                out_entry_d  = '0;
                out_fill_d   = '0;
                out_last_d   = 1'b1;
              end else begin
                state_d  = S_LIST;
                remain_d = count_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        // Emit the head word and rotate the row by one when the output register is free
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_DONE;
          out_entry_d  = link[1].entry;
          out_fill_d   = FILL_W'(count_q);
          out_last_d   = (remain_q == CW'(1));
          op           = OP_ROTATE;
          remain_d     = remain_q - CW'(1);
          if (remain_q == CW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      remain_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_entry_q  <= '0;
      out_fill_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      remain_q     <= remain_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_entry_q  <= out_entry_d;
      out_fill_q   <= out_fill_d;
      out_last_q   <= out_last_d;
    end
  end

  `SUS_ASSERT_ALWAYS(a_count_range, !rst_ni || count_q <= CW'(CAPACITY), "count over capacity")
  `SUS_ASSERT(a_occ_matches_count, $countones(occ_vec) == int'(count_q), "occupancy and count differ")
  `SUS_ASSERT(a_list_not_empty, (state_q == S_LIST) |-> (occ_vec[0] && remain_q != '0), "list with empty row")
  `SUS_ASSERT(a_insert_grows, (in_fire && in_i.command == CMD_INSERT && !full && !found) |=> (count_q == $past(count_q) + CW'(1)), "insert did not grow set")

  for (genvar i = 0; i + 1 < CAPACITY; i++) begin : g_order_chk
    // Order holds between list walks; the list rotation scrambles it only while a walk runs
    logic pair_ok;
    assign pair_ok = !occ_vec[i+1] ||
                     ($signed(link[i+1].entry) < $signed(link[i+2].entry));
    `SUS_ASSERT(a_sorted, (state_q == S_IDLE) |-> pair_ok, "row out of order")
  end

endmodule
`default_nettype wire
